FILE: rtl/core/hrtf_binaural_fir_assert.svh
// Assertion macros used by the top level of the binaural filter.
`ifndef HRTF_BINAURAL_FIR_ASSERT_SVH
`define HRTF_BINAURAL_FIR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/hbf_pkg.sv
package hbf_pkg;

  // Default sizes of the storage.
  localparam int MAX_TAPS_DEF      = 128;
  localparam int MAX_DELAY_DEF     = 64;
  localparam int HISTORY_DEPTH_DEF = 192;

  // Fixed field widths.
  localparam int SAMPLE_W  = 16;
  localparam int TAP_IDX_W = 7;
  localparam int DELAY_W   = 7;
  localparam int TAP_CNT_W = 8;
  localparam int VOL_W     = 16;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // Register reset values.
  localparam logic [VOL_W-1:0]     VOLUME_RESET    = 16'd4096;
  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = 8'd128;

  // Fixed-point scaling.
  localparam int MIX_SHIFT = 12;
  localparam int FIR_SHIFT = 15;

  // Register indexes on the configuration port.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLED      = 3'd0,
    REG_STEREO_INPUT = 3'd1,
    REG_VOLUME       = 3'd2,
    REG_LEFT_DELAY   = 3'd3,
    REG_RIGHT_DELAY  = 3'd4,
    REG_TAP_COUNT    = 3'd5
  } reg_idx_t;

  // Request kinds.
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_COEF  = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample_a;
    logic signed [SAMPLE_W-1:0] sample_b;
    logic                       ear;
    logic [TAP_IDX_W-1:0]       tap_index;
    logic signed [SAMPLE_W-1:0] coef_value;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;
    logic take_frame;
    logic take_pass;
    logic take_coef;
    logic write_hist;
    logic align;
    logic issue;
    logic load_out;
  } hbf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;
    logic aligned;
    logic last_tap;
    logic busy;
    logic slot_free;
  } hbf_status_t;

endpackage

FILE: rtl/core/hbf_ctrl.sv
module hbf_ctrl
  import hbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_valid,
  input  logic        frame_is_coef,
  input  logic        enabled,
  input  hbf_status_t status,
  output logic        frame_ready,
  output hbf_cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_WRITE  = 7'b0000100,
    ST_ALIGN  = 7'b0001000,
    ST_RUN    = 7'b0010000,
    ST_DRAIN  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the history clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    frame_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = !status.clear_done;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        frame_ready = 1'b1;
        if (frame_valid) begin
          if (frame_is_coef == CMD_COEF) begin
            cmd.take_coef = 1'b1;
          end else if (enabled) begin
            cmd.take_frame = 1'b1;
            state_next     = ST_WRITE;
          end else begin
            cmd.take_pass = 1'b1;
            state_next    = ST_FINISH;
          end
        end
      end
      ST_WRITE: begin
        cmd.write_hist = 1'b1;
        state_next     = ST_ALIGN;
      end
      ST_ALIGN: begin
        cmd.align = 1'b1;
        if (status.aligned) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (status.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/hbf_datapath.sv
module hbf_datapath
  import hbf_pkg::*;
#(
  parameter int MAX_TAPS      = MAX_TAPS_DEF,
  parameter int MAX_DELAY     = MAX_DELAY_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hbf_cmd_t             cmd,
  output hbf_status_t          status,
  input  frame_t               frame,
  input  logic                 stereo_input,
  input  logic [VOL_W-1:0]     volume,
  input  logic [DELAY_W-1:0]   left_delay,
  input  logic [DELAY_W-1:0]   right_delay,
  input  logic [TAP_CNT_W-1:0] tap_count,
  input  logic                 result_ready,
  output logic                 result_valid,
  output result_t              result
);

  localparam int PW     = $clog2(HISTORY_DEPTH);
  localparam int TIW    = $clog2(MAX_TAPS);
  localparam int TCW    = $clog2(MAX_TAPS + 1);
  localparam int DW     = $clog2(MAX_DELAY + 2);
  localparam int SW     = ((PW > DW) ? PW : DW) + 2;
  localparam int MIX_W  = SAMPLE_W + VOL_W + 2;
  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int ACC_W  = PROD_W + TIW;

  localparam logic [PW-1:0]           LAST_POS = PW'(HISTORY_DEPTH - 1);
  localparam logic signed [SW-1:0]    DEPTH_S  = SW'(HISTORY_DEPTH);
  localparam logic signed [SW-1:0]    LAST_S   = SW'(HISTORY_DEPTH - 1);
  localparam logic signed [MIX_W-1:0] MIX_MAX  = MIX_W'(32767);
  localparam logic signed [MIX_W-1:0] MIX_MIN  = MIX_W'(-32768);
  localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] ACC_MIN  = ACC_W'(-32768);

  // Storage.
  logic signed [SAMPLE_W-1:0] hist       [HISTORY_DEPTH];
  logic signed [SAMPLE_W-1:0] left_taps  [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] right_taps [MAX_TAPS];

  logic [PW-1:0]              clr_cnt;
  logic                       clear_done;
  logic [PW-1:0]              wpos;
  logic signed [MIX_W-1:0]    mix_prod;
  logic signed [MIX_W-1:0]    mix_shr;
  logic signed [SAMPLE_W-1:0] mix_sat;
  logic signed [SAMPLE_W:0]   mix_sum;
  logic                       hist_we;
  logic [PW-1:0]              hist_wa;
  logic signed [SAMPLE_W-1:0] hist_wd;
  logic signed [SAMPLE_W-1:0] hist_rd_l;
  logic signed [SAMPLE_W-1:0] hist_rd_r;
  logic signed [SAMPLE_W-1:0] tap_rd_l;
  logic signed [SAMPLE_W-1:0] tap_rd_r;
  logic                       coef_we;
  logic [TIW-1:0]             coef_wa;
  logic [DW-1:0]              dl_sat;
  logic [DW-1:0]              dr_sat;
  logic [TCW-1:0]             ntaps;
  logic [TCW-1:0]             tap_cnt;
  logic signed [SW-1:0]       diff_l;
  logic signed [SW-1:0]       diff_r;
  logic                       v1;
  logic                       v2;
  logic signed [PROD_W-1:0]   prod_l;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_l;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       pass_mode;
  logic signed [SAMPLE_W-1:0] pass_a;
  logic signed [SAMPLE_W-1:0] pass_b;

  // Floor shift of a filter sum back to Q1.15, saturated to 16 bits.
  function automatic logic signed [SAMPLE_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    s = v >>> FIR_SHIFT;
    if (s > ACC_MAX) begin
      sat_acc = SAMPLE_W'(ACC_MAX);
    end else if (s < ACC_MIN) begin
      sat_acc = SAMPLE_W'(ACC_MIN);
    end else begin
      sat_acc = s[SAMPLE_W-1:0];
    end
  endfunction

  // Delays limited to MAX_DELAY, tap count to the range 1 to MAX_TAPS.
  assign dl_sat = (32'(left_delay) > MAX_DELAY) ? DW'(MAX_DELAY) : DW'(left_delay);
  assign dr_sat = (32'(right_delay) > MAX_DELAY) ? DW'(MAX_DELAY) : DW'(right_delay);

  always_comb begin
    if (tap_count == '0) begin
      ntaps = TCW'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      ntaps = TCW'(MAX_TAPS);
    end else begin
      ntaps = TCW'(tap_count);
    end
  end

  // Downmix: mono or summed stereo, times the Q4.12 volume.
  assign mix_sum = stereo_input ?
                   ({frame.sample_a[SAMPLE_W-1], frame.sample_a} +
                    {frame.sample_b[SAMPLE_W-1], frame.sample_b}) :
                   {frame.sample_a[SAMPLE_W-1], frame.sample_a};

  always_ff @(posedge clk) begin
    if (cmd.take_frame) begin
      mix_prod <= mix_sum * $signed({1'b0, volume});
    end
  end

  assign mix_shr = mix_prod >>> MIX_SHIFT;

  always_comb begin
    if (mix_shr > MIX_MAX) begin
      mix_sat = SAMPLE_W'(MIX_MAX);
    end else if (mix_shr < MIX_MIN) begin
      mix_sat = SAMPLE_W'(MIX_MIN);
    end else begin
      mix_sat = mix_shr[SAMPLE_W-1:0];
    end
  end

  // Clearing pass and write pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      clear_done <= 1'b0;
      wpos       <= '0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + PW'(1);
        if (clr_cnt == LAST_POS) begin
          clear_done <= 1'b1;
        end
      end
      if (cmd.take_frame) begin
        wpos <= (wpos == LAST_POS) ? '0 : wpos + PW'(1);
      end
    end
  end

  // History memory: one write port, two registered read ports.
  assign hist_we = cmd.clear | cmd.write_hist;
  assign hist_wa = cmd.clear ? clr_cnt : wpos;
  assign hist_wd = cmd.clear ? '0 : mix_sat;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[hist_wa] <= hist_wd;
    end
    hist_rd_l <= hist[diff_l[PW-1:0]];
    hist_rd_r <= hist[diff_r[PW-1:0]];
  end

  // Coefficient tables; loads beyond the table are dropped.
  assign coef_we = cmd.take_coef & (32'(frame.tap_index) < MAX_TAPS);
  assign coef_wa = TIW'(frame.tap_index);

  always_ff @(posedge clk) begin
    if (coef_we && !frame.ear) begin
      left_taps[coef_wa] <= frame.coef_value;
    end
    if (coef_we && frame.ear) begin
      right_taps[coef_wa] <= frame.coef_value;
    end
    tap_rd_l <= left_taps[tap_cnt[TIW-1:0]];
    tap_rd_r <= right_taps[tap_cnt[TIW-1:0]];
  end

  // Read pointers: start at the newest sample minus the delay, wrapped
  // into the line, then step back one sample per tap.
  always_ff @(posedge clk) begin
    if (cmd.write_hist) begin
      diff_l  <= $signed(SW'(wpos)) - $signed(SW'(dl_sat));
      diff_r  <= $signed(SW'(wpos)) - $signed(SW'(dr_sat));
      tap_cnt <= '0;
    end else if (cmd.align) begin
      if (diff_l < 0) begin
        diff_l <= diff_l + DEPTH_S;
      end
      if (diff_r < 0) begin
        diff_r <= diff_r + DEPTH_S;
      end
    end else if (cmd.issue) begin
      diff_l  <= (diff_l == '0) ? LAST_S : diff_l - SW'(1);
      diff_r  <= (diff_r == '0) ? LAST_S : diff_r - SW'(1);
      tap_cnt <= tap_cnt + TCW'(1);
    end
  end

  // Multiply-accumulate pipeline, both ears side by side.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod_l <= hist_rd_l * tap_rd_l;
    prod_r <= hist_rd_r * tap_rd_r;
    if (cmd.write_hist) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (v2) begin
      acc_l <= acc_l + ACC_W'(prod_l);
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Pass-through samples for a disabled filter.
  always_ff @(posedge clk) begin
    if (cmd.take_pass) begin
      pass_mode <= 1'b1;
      pass_a    <= frame.sample_a;
      pass_b    <= stereo_input ? frame.sample_b : frame.sample_a;
    end else if (cmd.take_frame) begin
      pass_mode <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.out_left  <= pass_mode ? pass_a : sat_acc(acc_l);
      result.out_right <= pass_mode ? pass_b : sat_acc(acc_r);
    end
  end

  // Status back to the controller.
  assign status.clear_done = clear_done;
  assign status.aligned    = !diff_l[SW-1] && !diff_r[SW-1];
  assign status.last_tap   = (tap_cnt == ntaps - TCW'(1));
  assign status.busy       = v1 | v2;
  assign status.slot_free  = !result_valid || result_ready;

endmodule

FILE: rtl/core/hrtf_binaural_fir.sv
// Channel | Direction | Handshake                   | Payload
// frame   | in        | frame_valid / frame_ready   | frame_t (audio frame or coefficient)
// result  | out       | result_valid / result_ready | result_t (left and right samples)
// config  | in        | psel, penable, pwrite       | paddr, pwdata, prdata
//
// A filtered frame runs the write, align, run, drain and finish states before the next
// acceptance; the align state wraps a delay that reaches back past the start of the
// line, and both ears run one shared tap pass over the history memory's two read ports.
// A pass-through frame goes straight to the finish state; a coefficient load stays in idle.
// After reset the history line is cleared with frame_ready low.
// A result waiting in the output register stalls only the finish of the next frame.
module hrtf_binaural_fir
  import hbf_pkg::*;
#(
  parameter int MAX_TAPS      = MAX_TAPS_DEF,
  parameter int MAX_DELAY     = MAX_DELAY_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  frame_valid,
  output logic                  frame_ready,
  input  frame_t                frame,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                 enabled;
  logic                 stereo_input;
  logic [VOL_W-1:0]     volume;
  logic [DELAY_W-1:0]   left_delay;
  logic [DELAY_W-1:0]   right_delay;
  logic [TAP_CNT_W-1:0] tap_count;
  reg_idx_t             reg_idx;
  hbf_cmd_t             cmd;
  hbf_status_t          status;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      stereo_input <= 1'b0;
      volume       <= VOLUME_RESET;
      left_delay   <= '0;
      right_delay  <= '0;
      tap_count    <= TAP_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ENABLED:      enabled      <= pwdata[0];
        REG_STEREO_INPUT: stereo_input <= pwdata[0];
        REG_VOLUME:       volume       <= pwdata[VOL_W-1:0];
        REG_LEFT_DELAY:   left_delay   <= pwdata[DELAY_W-1:0];
        REG_RIGHT_DELAY:  right_delay  <= pwdata[DELAY_W-1:0];
        REG_TAP_COUNT:    tap_count    <= pwdata[TAP_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_ENABLED:      prdata = APB_DATA_W'(enabled);
      REG_STEREO_INPUT: prdata = APB_DATA_W'(stereo_input);
      REG_VOLUME:       prdata = APB_DATA_W'(volume);
      REG_LEFT_DELAY:   prdata = APB_DATA_W'(left_delay);
      REG_RIGHT_DELAY:  prdata = APB_DATA_W'(right_delay);
      REG_TAP_COUNT:    prdata = APB_DATA_W'(tap_count);
      default:          prdata = '0;
    endcase
  end

  hbf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .frame_valid   (frame_valid),
    .frame_is_coef (frame.cmd),
    .enabled       (enabled),
    .status        (status),
    .frame_ready   (frame_ready),
    .cmd           (cmd)
  );

  hbf_datapath #(
    .MAX_TAPS      (MAX_TAPS),
    .MAX_DELAY     (MAX_DELAY),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .frame        (frame),
    .stereo_input (stereo_input),
    .volume       (volume),
    .left_delay   (left_delay),
    .right_delay  (right_delay),
    .tap_count    (tap_count),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

  // Checks on the sequencing of the filter.
`include "hrtf_binaural_fir_assert.svh"

  `HBF_ASSERT_NOW(a_no_accept_while_clearing, !status.clear_done, !frame_ready,
                  "request accepted before the history clear finished")
  `HBF_ASSERT_NOW(a_pipe_empty_when_ready, frame_ready, !status.busy,
                  "multiply pipeline still busy while taking a request")
  `HBF_ASSERT_NEXT(a_coef_gives_no_result,
                   frame_valid && frame_ready && (frame.cmd == CMD_COEF),
                   !$rose(result_valid),
                   "coefficient load produced a result")

endmodule
